[rtl/cds_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cds_pkg
// Types, constants and the month length table for the calendar date step.
// -----------------------------------------------------------------------------
package cds_pkg;

  // Step direction
  typedef enum logic {
    OpNext = 1'b0,
    OpPrev = 1'b1
  } op_e;

  localparam logic [2:0]  DowLast     = 3'd6;     // Saturday
  localparam logic [2:0]  DowFirst    = 3'd0;     // Sunday
  localparam logic [3:0]  MonthJan    = 4'd0;
  localparam logic [3:0]  MonthFeb    = 4'd1;
  localparam logic [3:0]  MonthDec    = 4'd11;
  localparam logic [13:0] YearMax     = 14'd9999;
  localparam logic [13:0] YearMin     = 14'd0;
  localparam logic [4:0]  FebLeapDays = 5'd29;

  // One calendar date
  typedef struct packed {
    logic [2:0]  dow;
    logic [4:0]  dom;
    logic [3:0]  mon;
    logic [13:0] yr;
  } date_t;

  // One step result
  typedef struct packed {
    date_t date;
    logic  wrap;
  } result_t;

  // Days in a month; leap rule is year divisible by four
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [1:0] yr_lo);
    logic [4:0] len;
    unique case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    if (mon == MonthFeb && yr_lo == 2'd0) begin
      len = FebLeapDays;
    end
    return len;
  endfunction

endpackage

[rtl/cds_step_logic.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cds_step_logic
// Combinational next-day / previous-day step of one calendar date.
// -----------------------------------------------------------------------------
module cds_step_logic (
  input  cds_pkg::op_e     op_i,
  input  cds_pkg::date_t   date_i,
  output cds_pkg::result_t result_o
);
  import cds_pkg::*;

  logic [2:0]  dow_n;
  logic [3:0]  mon_c;
  logic [13:0] yr_c;
  logic [4:0]  len_cur;
  logic [4:0]  len_new;
  date_t       nd;
  logic        wrap;

  // Normalize out-of-range inputs: weekday 7 is Sunday, month clamps to
  // December, year saturates at the top
  always_comb begin
    dow_n   = (date_i.dow == 3'd7) ? DowFirst : date_i.dow;
    mon_c   = (date_i.mon > MonthDec) ? MonthDec : date_i.mon;
    yr_c    = (date_i.yr > YearMax) ? YearMax : date_i.yr;
    len_cur = month_len(mon_c, yr_c[1:0]);
  end

  // Step the date
  always_comb begin
    nd      = '{dow: dow_n, dom: date_i.dom, mon: mon_c, yr: yr_c};
    wrap    = 1'b0;
    len_new = '0;
    if (op_i == OpNext) begin
      nd.dow = (dow_n == DowLast) ? DowFirst : dow_n + 3'd1;
      if (date_i.dom >= len_cur) begin
        nd.dom = 5'd1;
        if (mon_c == MonthDec) begin
          nd.mon = MonthJan;
          if (yr_c >= YearMax) begin
            nd.yr = YearMin;
            wrap  = 1'b1;
          end else begin
            nd.yr = yr_c + 14'd1;
          end
        end else begin
          nd.mon = mon_c + 4'd1;
        end
      end else begin
        nd.dom = date_i.dom + 5'd1;
      end
    end else begin
      nd.dow = (dow_n == DowFirst) ? DowLast : dow_n - 3'd1;
      if (date_i.dom <= 5'd1) begin
        // last day of the previous month, possibly previous year
        if (mon_c == MonthJan) begin
          nd.mon = MonthDec;
          if (yr_c == YearMin) begin
            nd.yr = YearMax;
            wrap  = 1'b1;
          end else begin
            nd.yr = yr_c - 14'd1;
          end
        end else begin
          nd.mon = mon_c - 4'd1;
        end
        len_new = month_len(nd.mon, nd.yr[1:0]);
        nd.dom  = len_new;
      end else if (date_i.dom > len_cur) begin
        nd.dom = len_cur;
      end else begin
        nd.dom = date_i.dom - 5'd1;
      end
    end
  end

  assign result_o = '{date: nd, wrap: wrap};

endmodule

[rtl/calendar_date_step.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// calendar_date_step
// Next-day / previous-day calendar step with valid/ready channels.
// -----------------------------------------------------------------------------
// Accepts one date request per cycle and returns one result per request, in
// order. The path is one input register, then the date step logic into the
// output register. The throughput of one request per cycle holds as long as
// the output side takes results; a stalled output backs up through both
// registers before in_ready_o drops.
// Leap years are years divisible by four; the year wraps between 9999 and 0
// with year_wrapped_o set on the wrap.
module calendar_date_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [2:0]  day_of_week_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [3:0]  month_index_i,
  input  logic [13:0] year_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  new_day_of_week_o,
  output logic [4:0]  new_day_of_month_o,
  output logic [3:0]  new_month_index_o,
  output logic [13:0] new_year_number_o,
  output logic        year_wrapped_o
);
  import cds_pkg::*;

  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  op_e     op_q;
  date_t   date_q;
  result_t res_q;
  result_t res_d;
  logic    out_adv;
  logic    in_take;

  // Handshake: output register frees when empty or taken
  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = in_valid_q;
    end
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= op_e'(opcode_i);
      date_q <= '{dow: day_of_week_i, dom: day_of_month_i,
                  mon: month_index_i, yr: year_number_i};
    end
  end

  cds_step_logic u_step (
    .op_i     (op_q),
    .date_i   (date_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign new_day_of_week_o  = res_q.date.dow;
  assign new_day_of_month_o = res_q.date.dom;
  assign new_month_index_o  = res_q.date.mon;
  assign new_year_number_o  = res_q.date.yr;
  assign year_wrapped_o     = res_q.wrap;

endmodule

[sim/tb_calendar_date_step.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_calendar_date_step
// Self-checking bench for the next-day / previous-day calendar step.
// -----------------------------------------------------------------------------
// A directed set of month, leap and year-wrap boundaries comes first. Random
// requests follow: mostly valid dates weighted toward month ends and year
// edges, plus full-width noise on every field. Both channels insert random
// idle cycles, with bursts of back-to-back traffic. Every request is predicted
// when it is accepted, and each result is compared field by field, in order.
// -----------------------------------------------------------------------------

// Expected-result store plus the date predictor
class date_board;
  cds_pkg::result_t expected_q[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Days in a month; leap years are those divisible by four
  static function logic [4:0] days_in_month(logic [3:0] mon, logic [13:0] yr);
    logic [4:0] len;
    case (mon)
      cds_pkg::MonthFeb: len = (yr[1:0] == 2'd0) ? cds_pkg::FebLeapDays : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Date one day later or earlier, after clamping out-of-range fields
  static function cds_pkg::result_t step_date(cds_pkg::op_e op, cds_pkg::date_t d);
    cds_pkg::result_t r;
    logic [2:0]  dow;
    logic [4:0]  dom;
    logic [4:0]  len;
    logic [3:0]  mon;
    logic [13:0] yr;
    logic        wrap;
    dow  = (d.dow == 3'd7) ? cds_pkg::DowFirst : d.dow;
    mon  = (d.mon > cds_pkg::MonthDec) ? cds_pkg::MonthDec : d.mon;
    yr   = (d.yr > cds_pkg::YearMax) ? cds_pkg::YearMax : d.yr;
    wrap = 1'b0;
    len  = days_in_month(mon, yr);
    if (op == cds_pkg::OpNext) begin
      dow = (dow == cds_pkg::DowLast) ? cds_pkg::DowFirst : dow + 3'd1;
      if (d.dom >= len) begin
        dom = 5'd1;
        if (mon == cds_pkg::MonthDec) begin
          mon = cds_pkg::MonthJan;
          if (yr == cds_pkg::YearMax) begin
            yr   = cds_pkg::YearMin;
            wrap = 1'b1;
          end else begin
            yr = yr + 14'd1;
          end
        end else begin
          mon = mon + 4'd1;
        end
      end else begin
        dom = d.dom + 5'd1;
      end
    end else begin
      dow = (dow == cds_pkg::DowFirst) ? cds_pkg::DowLast : dow - 3'd1;
      if (d.dom <= 5'd1) begin
        // day zero or one falls back to the end of the previous month
        if (mon == cds_pkg::MonthJan) begin
          mon = cds_pkg::MonthDec;
          if (yr == cds_pkg::YearMin) begin
            yr   = cds_pkg::YearMax;
            wrap = 1'b1;
          end else begin
            yr = yr - 14'd1;
          end
        end else begin
          mon = mon - 4'd1;
        end
        dom = days_in_month(mon, yr);
      end else if (d.dom > len) begin
        dom = len;
      end else begin
        dom = d.dom - 5'd1;
      end
    end
    r.date.dow = dow;
    r.date.dom = dom;
    r.date.mon = mon;
    r.date.yr  = yr;
    r.wrap     = wrap;
    return r;
  endfunction

  function void note_request(cds_pkg::op_e op, cds_pkg::date_t d);
    expected_q.push_back(step_date(op, d));
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task check_result(cds_pkg::result_t got);
    cds_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result, weekday", got.date.dow, -1);
      return;
    end
    want = expected_q.pop_front();
    if (got.date.dow != want.date.dow)
      report_mismatch("new_day_of_week", got.date.dow, want.date.dow);
    if (got.date.dom != want.date.dom)
      report_mismatch("new_day_of_month", got.date.dom, want.date.dom);
    if (got.date.mon != want.date.mon)
      report_mismatch("new_month_index", got.date.mon, want.date.mon);
    if (got.date.yr != want.date.yr)
      report_mismatch("new_year_number", got.date.yr, want.date.yr);
    if (got.wrap != want.wrap)
      report_mismatch("year_wrapped", got.wrap, want.wrap);
  endtask
endclass

module tb_calendar_date_step;
  import cds_pkg::*;

  localparam int unsigned RandomRequests = 1530;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic [2:0]  day_of_week_i = '0;
  logic [4:0]  day_of_month_i = '0;
  logic [3:0]  month_index_i = '0;
  logic [13:0] year_number_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  new_day_of_week_o;
  logic [4:0]  new_day_of_month_o;
  logic [3:0]  new_month_index_o;
  logic [13:0] new_year_number_o;
  logic        year_wrapped_o;

  bit        send_burst = 1'b0;
  bit        take_burst = 1'b0;
  date_board board = new();

  calendar_date_step DUT (.*);

  always #6 clk_i = ~clk_i;

  // Idle cycles before the next transfer; bursts run with none
  function automatic int unsigned pick_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  // Present one request and hold it until accepted
  task automatic drive_request(op_e op, logic [2:0] dow, logic [4:0] dom,
                               logic [3:0] mon, logic [13:0] yr);
    int unsigned gap;
    date_t d;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    day_of_week_i  <= dow;
    day_of_month_i <= dom;
    month_index_i  <= mon;
    year_number_i  <= yr;
    do @(posedge clk_i); while (!in_ready_o);
    d.dow = dow;
    d.dom = dom;
    d.mon = mon;
    d.yr  = yr;
    board.note_request(op, d);
  endtask

  // Year near either wrap point, or anywhere
  function automatic logic [13:0] pick_year();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3, 4: return 14'($urandom_range(0, 4));
        default:       return YearMax - 14'($urandom_range(0, 3));
      endcase
    end
    return 14'($urandom_range(0, 9999));
  endfunction

  // Mostly well-formed dates leaning on month ends, the rest raw noise
  task automatic pick_request(output op_e op, output date_t d);
    logic [4:0] len;
    op    = op_e'($urandom_range(0, 1));
    d.dow = 3'($urandom_range(0, 6));
    d.mon = 4'($urandom_range(0, 11));
    d.yr  = pick_year();
    len   = board.days_in_month(d.mon, d.yr);
    case ($urandom_range(0, 9))
      0, 1: begin
        d.dow = 3'($urandom);
        d.dom = 5'($urandom);
        d.mon = 4'($urandom);
        d.yr  = 14'($urandom);
      end
      2, 3: begin
        case ($urandom_range(0, 3))
          0:       d.dom = 5'd1;
          1:       d.dom = 5'd2;
          2:       d.dom = len - 5'd1;
          default: d.dom = len;
        endcase
      end
      4: begin
        d.mon = $urandom_range(0, 1) ? MonthDec : MonthJan;
        d.dom = (d.mon == MonthDec) ? 5'd31 : 5'd1;
        d.yr  = $urandom_range(0, 1) ? YearMax : YearMin;
      end
      default: d.dom = 5'($urandom_range(1, len));
    endcase
  endtask

  // Result side: random back-pressure, check each accepted result
  initial begin
    int unsigned gap;
    result_t got;
    wait (rst_ni);
    forever begin
      gap = pick_gap(take_burst);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.date.dow = new_day_of_week_o;
      got.date.dom = new_day_of_month_o;
      got.date.mon = new_month_index_o;
      got.date.yr  = new_year_number_o;
      got.wrap     = year_wrapped_o;
      board.check_result(got);
    end
  end

  // Request side
  initial begin
    op_e   op;
    date_t d;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // year wraps both ways
    drive_request(OpNext, 3'd6, 5'd31, MonthDec, YearMax);
    drive_request(OpPrev, 3'd0, 5'd1, MonthJan, YearMin);
    // leap and common February, both directions
    drive_request(OpNext, 3'd3, 5'd28, MonthFeb, 14'd2024);
    drive_request(OpNext, 3'd4, 5'd29, MonthFeb, 14'd2024);
    drive_request(OpNext, 3'd2, 5'd28, MonthFeb, 14'd2023);
    drive_request(OpPrev, 3'd5, 5'd1, 4'd2, 14'd2024);
    drive_request(OpPrev, 3'd3, 5'd1, 4'd2, 14'd2023);
    drive_request(OpPrev, 3'd1, 5'd1, 4'd2, YearMin);
    drive_request(OpNext, 3'd1, 5'd30, MonthFeb, 14'd2023);
    // weekday seven
    drive_request(OpNext, 3'd7, 5'd10, 4'd4, 14'd1990);
    drive_request(OpPrev, 3'd7, 5'd10, 4'd4, 14'd1990);
    // months past December
    drive_request(OpNext, 3'd2, 5'd31, 4'd15, 14'd100);
    drive_request(OpPrev, 3'd2, 5'd0, 4'd12, 14'd100);
    // years past 9999
    drive_request(OpNext, 3'd5, 5'd31, MonthDec, 14'h3fff);
    drive_request(OpPrev, 3'd5, 5'd15, 4'd6, 14'h3fff);
    // day zero both ways, including a backward wrap
    drive_request(OpNext, 3'd0, 5'd0, 4'd5, 14'd777);
    drive_request(OpPrev, 3'd0, 5'd0, MonthJan, YearMin);
    // day past the month length both ways
    drive_request(OpPrev, 3'd4, 5'd31, 4'd3, 14'd1500);
    drive_request(OpNext, 3'd4, 5'd31, 4'd3, 14'd1500);
    // plain mid-month steps
    drive_request(OpNext, 3'd3, 5'd15, 4'd5, 14'd2000);
    drive_request(OpPrev, 3'd0, 5'd10, 4'd6, 14'd1999);

    for (int n = 0; n < RandomRequests; n++) begin
      pick_request(op, d);
      drive_request(op, d.dow, d.dom, d.mon, d.yr);
    end
    in_valid_i <= 1'b0;

    // drain, then wait out any stray result
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("calendar_date_step verification clean");
    end else begin
      $display("calendar_date_step verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("calendar_date_step verification failed");
    $finish;
  end

endmodule
